@@ design/prs_pkg.sv @@
// Shared constants, types and the microcode program for the polyline spacing resampler.
// No dependencies; every other file in the project imports this package.
package prs_pkg;

   // Fixed field widths
   localparam int COORD_W           = 18;
   localparam int SPACING_W         = 16;
   localparam int SPACING_FRAC_BITS = 8;

   // Defaults for the top level parameters
   localparam int DEF_MAX_SPLIT_LEVEL = 5;
   localparam int DEF_COORD_FRAC_BITS = 8;

   // Register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_MIN = 1'b0;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_MAX = 1'b1;
   localparam logic [SPACING_W-1:0]  MIN_SPACING_RST = 16'd26;
   localparam logic [SPACING_W-1:0]  MAX_SPACING_RST = 16'd256;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [SPACING_W-1:0]      spacing_type;

   // Datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_WAIT      = 4'd0;
   localparam logic [OP_W-1:0] OP_DIFF      = 4'd1;
   localparam logic [OP_W-1:0] OP_SQX       = 4'd2;
   localparam logic [OP_W-1:0] OP_SQY       = 4'd3;
   localparam logic [OP_W-1:0] OP_SQMIN     = 4'd4;
   localparam logic [OP_W-1:0] OP_SQMAX     = 4'd5;
   localparam logic [OP_W-1:0] OP_TEST      = 4'd6;
   localparam logic [OP_W-1:0] OP_LEVEL     = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT_HELD = 4'd8;
   localparam logic [OP_W-1:0] OP_EMIT_MID  = 4'd9;
   localparam logic [OP_W-1:0] OP_TAKE      = 4'd10;
   localparam logic [OP_W-1:0] OP_EMIT_END  = 4'd11;
   localparam logic [OP_W-1:0] OP_MERGE     = 4'd12;
   localparam logic [OP_W-1:0] OP_EMIT_LAST = 4'd13;

   // Branch conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] CND_ALWAYS = 3'd0;
   localparam logic [COND_W-1:0] CND_NOHELD = 3'd1;
   localparam logic [COND_W-1:0] CND_LESS   = 3'd2;
   localparam logic [COND_W-1:0] CND_GROW   = 3'd3;
   localparam logic [COND_W-1:0] CND_SPLIT  = 3'd4;
   localparam logic [COND_W-1:0] CND_MORE   = 3'd5;
   localparam logic [COND_W-1:0] CND_FIN    = 3'd6;

   // Program steps
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] ST_WAIT  = 4'd0;
   localparam logic [PC_W-1:0] ST_DIFF  = 4'd1;
   localparam logic [PC_W-1:0] ST_SQX   = 4'd2;
   localparam logic [PC_W-1:0] ST_SQY   = 4'd3;
   localparam logic [PC_W-1:0] ST_SQMIN = 4'd4;
   localparam logic [PC_W-1:0] ST_SQMAX = 4'd5;
   localparam logic [PC_W-1:0] ST_TEST  = 4'd6;
   localparam logic [PC_W-1:0] ST_LEVEL = 4'd7;
   localparam logic [PC_W-1:0] ST_EMITH = 4'd8;
   localparam logic [PC_W-1:0] ST_EMITM = 4'd9;
   localparam logic [PC_W-1:0] ST_AFTER = 4'd10;
   localparam logic [PC_W-1:0] ST_FINAL = 4'd11;
   localparam logic [PC_W-1:0] ST_MERGE = 4'd12;
   localparam logic [PC_W-1:0] ST_LAST  = 4'd13;
   localparam logic [PC_W-1:0] ST_FIRST = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   tgt_t;
      logic [PC_W-1:0]   tgt_f;
   } ucode_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            go;
   } ctrl_type;

   typedef struct packed {
      logic in_valid;
      logic held_valid;
      logic fin;
      logic less;
      logic grow;
      logic split;
      logic more;
      logic out_free;
   } status_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         ST_WAIT:  w = '{OP_WAIT,      CND_ALWAYS, ST_DIFF,  ST_DIFF};
         ST_DIFF:  w = '{OP_DIFF,      CND_NOHELD, ST_FIRST, ST_SQX};
         ST_SQX:   w = '{OP_SQX,       CND_ALWAYS, ST_SQY,   ST_SQY};
         ST_SQY:   w = '{OP_SQY,       CND_ALWAYS, ST_SQMIN, ST_SQMIN};
         ST_SQMIN: w = '{OP_SQMIN,     CND_ALWAYS, ST_SQMAX, ST_SQMAX};
         ST_SQMAX: w = '{OP_SQMAX,     CND_ALWAYS, ST_TEST,  ST_TEST};
         ST_TEST:  w = '{OP_TEST,      CND_LESS,   ST_MERGE, ST_LEVEL};
         ST_LEVEL: w = '{OP_LEVEL,     CND_GROW,   ST_LEVEL, ST_EMITH};
         ST_EMITH: w = '{OP_EMIT_HELD, CND_SPLIT,  ST_EMITM, ST_AFTER};
         ST_EMITM: w = '{OP_EMIT_MID,  CND_MORE,   ST_EMITM, ST_AFTER};
         ST_AFTER: w = '{OP_TAKE,      CND_FIN,    ST_FINAL, ST_WAIT};
         ST_FINAL: w = '{OP_EMIT_END,  CND_ALWAYS, ST_WAIT,  ST_WAIT};
         ST_MERGE: w = '{OP_MERGE,     CND_FIN,    ST_LAST,  ST_WAIT};
         ST_LAST:  w = '{OP_EMIT_LAST, CND_ALWAYS, ST_WAIT,  ST_WAIT};
         ST_FIRST: w = '{OP_TAKE,      CND_FIN,    ST_FINAL, ST_WAIT};
         default:  w = '{OP_WAIT,      CND_ALWAYS, ST_WAIT,  ST_WAIT};
      endcase
      return w;
   endfunction

   function automatic logic is_emit(input logic [OP_W-1:0] op);
      return (op == OP_EMIT_HELD) || (op == OP_EMIT_MID) ||
             (op == OP_EMIT_END)  || (op == OP_EMIT_LAST);
   endfunction

endpackage

@@ design/prs_channels.sv @@
// Valid/ready channel interfaces: vertex requests and resampled vertex responses.
// Depends on prs_pkg for the coordinate type.
interface prs_req_if;
   import prs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      final_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input final_vertex,
                   output ready);
endinterface

interface prs_rsp_if;
   import prs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   logic      out_last;

   modport source (output valid, output out_x, output out_y, output out_last,
                   input ready);
   modport sink   (input valid, input out_x, input out_y, input out_last,
                   output ready);
endinterface

@@ design/prs_csr.sv @@
// APB-style register file holding the min and max spacing registers.
// Depends on prs_pkg.
module prs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [prs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [prs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [prs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output prs_pkg::spacing_type             min_spacing,
   output prs_pkg::spacing_type             max_spacing
);
   import prs_pkg::*;

   spacing_type                min_ff, min_in;
   spacing_type                max_ff, max_in;
   logic [CSR_ADDR_W-3:0]      idx;
   logic                       wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_IDX_MIN: min_in = pwdata[SPACING_W-1:0];
            CSR_IDX_MAX: max_in = pwdata[SPACING_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_IDX_MIN: prdata = CSR_DATA_W'(min_ff);
         CSR_IDX_MAX: prdata = CSR_DATA_W'(max_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_SPACING_RST;
         max_ff <= MAX_SPACING_RST;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign min_spacing = min_ff;
   assign max_spacing = max_ff;

endmodule

@@ design/prs_sequencer.sv @@
// Microcode sequencer: step counter, program ROM lookup and conditional branching.
// Depends on prs_pkg for the control word format and the program.
module prs_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  prs_pkg::status_type status,
   output prs_pkg::ctrl_type   ctrl
);
   import prs_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_type       word;
   logic            cond_hit;
   logic            go;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      unique case (word.cond)
         CND_ALWAYS: cond_hit = 1'b1;
         CND_NOHELD: cond_hit = !status.held_valid;
         CND_LESS:   cond_hit = status.less;
         CND_GROW:   cond_hit = status.grow;
         CND_SPLIT:  cond_hit = status.split;
         CND_MORE:   cond_hit = status.more;
         CND_FIN:    cond_hit = status.fin;
         default:    cond_hit = 1'b1;
      endcase
   end

   // a step stalls while waiting for an input beat or for room in the output register
   always_comb begin
      priority if (word.op == OP_WAIT) begin
         go = status.in_valid;
      end else if (is_emit(word.op)) begin
         go = status.out_free;
      end else begin
         go = 1'b1;
      end
   end

   assign pc_in = go ? (cond_hit ? word.tgt_t : word.tgt_f) : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl.op = word.op;
   assign ctrl.go = go;

endmodule

@@ design/prs_datapath.sv @@
// Resampler datapath: vertex registers, shared squarer, spacing compare,
// split interpolation accumulators and the output register. Driven by prs_sequencer.
// Depends on prs_pkg and the channel interfaces in prs_channels.
module prs_datapath #(
   parameter int MAX_SPLIT_LEVEL = prs_pkg::DEF_MAX_SPLIT_LEVEL,
   parameter int COORD_FRAC_BITS = prs_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   prs_req_if.sink              req_bus,
   prs_rsp_if.source            rsp_bus,
   input  prs_pkg::spacing_type min_spacing,
   input  prs_pkg::spacing_type max_spacing,
   input  prs_pkg::ctrl_type    ctrl,
   output prs_pkg::status_type  status
);
   import prs_pkg::*;

   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int BASE    = 2 * COORD_FRAC_BITS - 2 * SPACING_FRAC_BITS;
   localparam int LSH     = (BASE > 0) ? BASE : 0;
   localparam int RSH     = (BASE < 0) ? -BASE : 0;
   localparam int LEFT_W  = PROD_W + RSH;
   localparam int RIGHT_W = PROD_W + LSH + 2 * MAX_SPLIT_LEVEL;
   localparam int CMP_W   = (LEFT_W > RIGHT_W) ? LEFT_W : RIGHT_W;
   localparam int LVL_W   = $clog2(MAX_SPLIT_LEVEL + 1);
   localparam int CNT_W   = MAX_SPLIT_LEVEL;
   localparam int ACC_W   = DIFF_W + MAX_SPLIT_LEVEL;

   coord_type                 end_x_ff, end_x_in, end_y_ff, end_y_in;
   coord_type                 held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic                      fin_ff, fin_in;
   logic                      held_valid_ff, held_valid_in;
   logic signed [DIFF_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [PROD_W-1:0]         prod_ff, prod_in, d2_ff, d2_in;
   logic [CMP_W-1:0]          lim_ff, lim_in;
   logic [LVL_W-1:0]          lvl_ff, lvl_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   coord_type                 rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic signed [DIFF_W-1:0]  sq_op;
   logic signed [PROD_W-1:0]  sq_res;
   logic [CMP_W-1:0]          d2_cmp;
   logic signed [DIFF_W-1:0]  sum_x, sum_y;
   coord_type                 mid_x, mid_y;
   logic [CNT_W:0]            span;
   logic                      less, grow;
   logic                      out_free;
   logic                      step;

   assign step     = ctrl.go;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (ctrl.op == OP_WAIT);

   // one shared squarer, operand picked by the step
   always_comb begin
      unique case (ctrl.op)
         OP_SQX:   sq_op = dx_ff;
         OP_SQY:   sq_op = dy_ff;
         OP_SQMIN: sq_op = signed'(DIFF_W'(min_spacing));
         OP_SQMAX: sq_op = signed'(DIFF_W'(max_spacing));
         default:  sq_op = dx_ff;
      endcase
   end
   assign sq_res = sq_op * sq_op;

   // distance and limit brought to the same scale
   assign d2_cmp = CMP_W'(d2_ff) << RSH;
   assign less   = d2_cmp < lim_ff;
   assign grow   = (lvl_ff != LVL_W'(MAX_SPLIT_LEVEL)) && (d2_cmp > lim_ff);

   // floor midpoint
   assign sum_x = {held_x_ff[COORD_W-1], held_x_ff} + {end_x_ff[COORD_W-1], end_x_ff};
   assign sum_y = {held_y_ff[COORD_W-1], held_y_ff} + {end_y_ff[COORD_W-1], end_y_ff};

   // interior point: held + floor(d * i / 2^lvl), acc holds d * i
   assign mid_x = COORD_W'(acc_x_ff >>> lvl_ff) + held_x_ff;
   assign mid_y = COORD_W'(acc_y_ff >>> lvl_ff) + held_y_ff;
   assign span  = (CNT_W + 1)'(1) << lvl_ff;

   always_comb begin
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      fin_in        = fin_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      held_valid_in = held_valid_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      prod_in       = prod_ff;
      d2_in         = d2_ff;
      lim_in        = lim_ff;
      lvl_in        = lvl_ff;
      cnt_in        = cnt_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;

      if (step) begin
         unique case (ctrl.op)
            OP_WAIT: begin
               end_x_in = req_bus.vertex_x;
               end_y_in = req_bus.vertex_y;
               fin_in   = req_bus.final_vertex;
            end
            OP_DIFF: begin
               dx_in = {end_x_ff[COORD_W-1], end_x_ff} - {held_x_ff[COORD_W-1], held_x_ff};
               dy_in = {end_y_ff[COORD_W-1], end_y_ff} - {held_y_ff[COORD_W-1], held_y_ff};
            end
            OP_SQX: begin
               prod_in = unsigned'(sq_res);
            end
            OP_SQY: begin
               prod_in = unsigned'(sq_res);
               d2_in   = prod_ff;
            end
            OP_SQMIN: begin
               prod_in = unsigned'(sq_res);
               d2_in   = d2_ff + prod_ff;
            end
            OP_SQMAX: begin
               prod_in = unsigned'(sq_res);
               lim_in  = CMP_W'(prod_ff) << LSH;
            end
            OP_TEST: begin
               lim_in = CMP_W'(prod_ff) << LSH;
               lvl_in = '0;
            end
            OP_LEVEL: begin
               if (grow) begin
                  lvl_in = lvl_ff + 1'b1;
                  lim_in = lim_ff << 2;
               end
            end
            OP_EMIT_HELD: begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = held_x_ff;
               rsp_y_in     = held_y_ff;
               rsp_last_in  = 1'b0;
               acc_x_in     = ACC_W'(dx_ff);
               acc_y_in     = ACC_W'(dy_ff);
               cnt_in       = CNT_W'(span - 1'b1);
            end
            OP_EMIT_MID: begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = mid_x;
               rsp_y_in     = mid_y;
               rsp_last_in  = 1'b0;
               acc_x_in     = acc_x_ff + ACC_W'(dx_ff);
               acc_y_in     = acc_y_ff + ACC_W'(dy_ff);
               cnt_in       = cnt_ff - 1'b1;
            end
            OP_TAKE: begin
               held_x_in     = end_x_ff;
               held_y_in     = end_y_ff;
               held_valid_in = 1'b1;
            end
            OP_EMIT_END: begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = end_x_ff;
               rsp_y_in      = end_y_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
            end
            OP_MERGE: begin
               held_x_in = sum_x[DIFF_W-1:1];
               held_y_in = sum_y[DIFF_W-1:1];
            end
            OP_EMIT_LAST: begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = held_x_ff;
               rsp_y_in      = held_y_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      fin_ff      <= fin_in;
      held_x_ff   <= held_x_in;
      held_y_ff   <= held_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      d2_ff       <= d2_in;
      lim_ff      <= lim_in;
      lvl_ff      <= lvl_in;
      cnt_ff      <= cnt_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_x    = rsp_x_ff;
   assign rsp_bus.out_y    = rsp_y_ff;
   assign rsp_bus.out_last = rsp_last_ff;

   assign status.in_valid   = req_bus.valid;
   assign status.held_valid = held_valid_ff;
   assign status.fin        = fin_ff;
   assign status.less       = less;
   assign status.grow       = grow;
   assign status.split      = (lvl_ff != '0);
   assign status.more       = (cnt_ff != CNT_W'(1));
   assign status.out_free   = out_free;

endmodule

@@ design/polyline_spacing_resampler.sv @@
// The sequencer takes one program step per cycle, except while a step stalls for an input
// beat or for room in the output register, and works around a single shared squarer. A new
// vertex is accepted only at the wait step, once the program has finished the previous one.
// Reset (synchronous, active high): step counter to the wait step, no vertex held, output
// empty, min_spacing 26, max_spacing 256.
module polyline_spacing_resampler #(
   parameter int MAX_SPLIT_LEVEL = prs_pkg::DEF_MAX_SPLIT_LEVEL,
   parameter int COORD_FRAC_BITS = prs_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   prs_req_if.sink                        req_bus,
   prs_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [prs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [prs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [prs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import prs_pkg::*;

   // Spacing registers; software keeps max_spacing at least twice min_spacing.
   spacing_type min_spacing;
   spacing_type max_spacing;

   // Control word out of the sequencer, condition flags back from the datapath.
   ctrl_type    ctrl;
   status_type  status;

   prs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .min_spacing (min_spacing),
      .max_spacing (max_spacing)
   );

   // Program: wait for a beat, form the deltas, square dx, dy, min and max on the one
   // squarer, test for a merge, then climb split levels one per cycle. Emission steps
   // stall while the output register is still full; interior points come out one per
   // cycle from running sums of the delta.
   prs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   prs_datapath #(
      .MAX_SPLIT_LEVEL (MAX_SPLIT_LEVEL),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .min_spacing (min_spacing),
      .max_spacing (max_spacing),
      .ctrl        (ctrl),
      .status      (status)
   );

   // An accepted beat always moves the program on to forming the deltas.
   a_accept_to_diff: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> (ctrl.op == OP_DIFF))
      else $error("accepted beat not followed by delta step");

   // Interior points only exist when a split level was chosen.
   a_mid_needs_split: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_EMIT_MID) |-> status.split)
      else $error("interior point emitted at split level zero");

   // Closing beat of a polyline leaves nothing held.
   a_last_drops_held: assert property (@(posedge clock) disable iff (reset)
      (ctrl.go && (ctrl.op == OP_EMIT_END || ctrl.op == OP_EMIT_LAST))
      |=> !status.held_valid)
      else $error("vertex still held after final beat");

   // Every emission step that goes puts a beat in the output register.
   a_emit_fills_out: assert property (@(posedge clock) disable iff (reset)
      (ctrl.go && is_emit(ctrl.op)) |=> rsp_bus.valid)
      else $error("emission step left output register empty");

endmodule
